>>> rtl/gwm_pkg.sv
// Shared constants, types and helper functions for the grid word match counter.
package gwm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int CHAR_W  = 8;
  localparam int PAT_W   = 64;
  localparam int PLEN_W  = 4;
  localparam int DIM_W   = 11;
  localparam int TOTAL_W = 22;

  localparam int COL_W = $clog2(MAX_COLUMNS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // wide enough for a clamped dimension and for position + 1
  localparam int DIM_MAX = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int CMP_W   = ($clog2(DIM_MAX + 1) > DIM_W) ? $clog2(DIM_MAX + 1) + 1 : DIM_W + 1;

  localparam int APB_AW = 5;
  localparam int APB_DW = 64;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [PLEN_W-1:0]  LEN_RST   = PLEN_W'(1);
  localparam logic [DIM_W-1:0]   DIM_RST   = DIM_W'(1024);

  typedef logic [MAX_PATTERN-1:0] prog_t;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1,
    REG_GRID_COLUMNS   = 2'd2,
    REG_GRID_ROWS      = 2'd3
  } reg_idx_t;

  function automatic logic [PLEN_W-1:0] clamp_len(input logic [PLEN_W-1:0] raw);
    logic [PLEN_W-1:0] v;
    if (raw == '0) begin
      v = PLEN_W'(1);
    end else if (int'(raw) > MAX_PATTERN) begin
      v = PLEN_W'(MAX_PATTERN);
    end else begin
      v = raw;
    end
    return v;
  endfunction

  function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] raw, input int hi);
    logic [CMP_W-1:0] v;
    if (raw == '0) begin
      v = CMP_W'(1);
    end else if (int'(raw) > hi) begin
      v = CMP_W'(hi);
    end else begin
      v = CMP_W'(raw);
    end
    return v;
  endfunction

  // bit k set when pattern byte k equals ch, for k below len
  function automatic prog_t char_mask(input logic [PAT_W-1:0] pat,
                                      input logic [PLEN_W-1:0] len,
                                      input logic [CHAR_W-1:0] ch);
    prog_t m;
    m = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      m[k] = (pat[CHAR_W*k +: CHAR_W] == ch) && (k < int'(len));
    end
    return m;
  endfunction

  // one-hot on the progress bit that marks a full match
  function automatic prog_t hit_mask(input logic [PLEN_W-1:0] len);
    prog_t m;
    m = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      m[k] = ((k + 1) == int'(len));
    end
    return m;
  endfunction

endpackage

>>> rtl/grid_word_match_counter_top.sv
// Grid word match counter: top level with column store, match logic and APB registers.
//
// Usage:
// - Input channel (in_valid / in_stall / in_cell_char): one grid cell per request,
//   in raster order. A request is taken when in_valid is high and in_stall is low.
// - Result channel (out_valid / out_stall / out_match_total): one request per
//   finished grid, carrying the horizontal plus vertical match count (saturating).
// - APB port: pattern bytes, pattern length, grid columns, grid rows at byte
//   offsets 0, 8, 16, 24. Write only while the block is idle.
// - Throughput: one cell per cycle while in_stall is low. Each cell does one
//   read-modify-write of the column store (1K x 8 sync RAM, one read and one
//   write port); the read issues on accept, the write-back when the cell leaves stage 1.
// - Result: out_valid rises once the last cell of the grid has passed stage 1
//   and its count has been loaded into the result register.
// - Stall: the result register holds while out_stall is high. Cells keep
//   flowing until the last cell of the next grid reaches the match stage; only
//   then is in_stall raised.
// - Reset (rst_n low, synchronous): positions, progress, total and the result
//   register valid flag clear, config returns to defaults. No clearing pass: the
//   first row of every grid ignores the column store read.
module grid_word_match_counter_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gwm_pkg::CHAR_W-1:0]   in_cell_char,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gwm_pkg::TOTAL_W-1:0]  out_match_total,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gwm_pkg::APB_AW-1:0]   paddr,
  input  logic [gwm_pkg::APB_DW-1:0]   pwdata,
  output logic [gwm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import gwm_pkg::*;

  // ---------------- configuration registers ----------------
  logic [PAT_W-1:0]  pattern_bytes_r;
  logic [PLEN_W-1:0] pattern_length_r;
  logic [DIM_W-1:0]  grid_columns_r;
  logic [DIM_W-1:0]  grid_rows_r;

  logic     cfg_wr;
  reg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_bytes_r  <= '0;
      pattern_length_r <= LEN_RST;
      grid_columns_r   <= DIM_RST;
      grid_rows_r      <= DIM_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PATTERN_BYTES:  pattern_bytes_r  <= pwdata[PAT_W-1:0];
        REG_PATTERN_LENGTH: pattern_length_r <= pwdata[PLEN_W-1:0];
        REG_GRID_COLUMNS:   grid_columns_r   <= pwdata[DIM_W-1:0];
        REG_GRID_ROWS:      grid_rows_r      <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_BYTES:  prdata = APB_DW'(pattern_bytes_r);
      REG_PATTERN_LENGTH: prdata = APB_DW'(pattern_length_r);
      REG_GRID_COLUMNS:   prdata = APB_DW'(grid_columns_r);
      REG_GRID_ROWS:      prdata = APB_DW'(grid_rows_r);
      default:            prdata = '0;
    endcase
  end

  // effective (clamped) settings
  logic [PLEN_W-1:0] len_c;
  logic [CMP_W-1:0]  cols_c;
  logic [CMP_W-1:0]  rows_c;
  prog_t             hit_m;

  assign len_c  = clamp_len(pattern_length_r);
  assign cols_c = clamp_dim(grid_columns_r, MAX_COLUMNS);
  assign rows_c = clamp_dim(grid_rows_r, MAX_ROWS);
  assign hit_m  = hit_mask(len_c);

  // ---------------- stage 0: position tracking, column store read ----------------
  logic [COL_W-1:0] column_position_r;
  logic [ROW_W-1:0] row_position_r;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] row_inc;
  logic             row_end;
  logic             frame_end;
  logic             in_acc;

  assign col_inc   = CMP_W'(column_position_r) + CMP_W'(1);
  assign row_inc   = CMP_W'(row_position_r) + CMP_W'(1);
  assign row_end   = (col_inc >= cols_c);
  assign frame_end = row_end && (row_inc >= rows_c);
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_position_r <= '0;
      row_position_r    <= '0;
    end else if (in_acc) begin
      if (row_end) begin
        column_position_r <= '0;
        row_position_r    <= frame_end ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_position_r <= col_inc[COL_W-1:0];
      end
    end
  end

  // ---------------- stage 1: match update, write-back ----------------
  logic             s1_valid_r;
  prog_t            s1_mask_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_first_row_r;
  logic             s1_row_end_r;
  logic             s1_last_r;
  logic             s1_fwd_r;
  prog_t            fwd_data_r;
  prog_t            rd_data_r;

  prog_t               row_progress_r;
  prog_t               row_progress_nxt;
  logic [TOTAL_W-1:0]  running_total_r;
  logic [TOTAL_W-1:0]  running_total_nxt;
  logic [TOTAL_W:0]    total_sum;
  prog_t               prev_col;
  prog_t               vv;
  logic                hit_h;
  logic                hit_v;
  logic                s1_go;
  logic                s1_done;

  logic                out_valid_r;
  logic [TOTAL_W-1:0]  out_total_r;

  // only a grid-final cell needs the result register
  assign s1_go    = !(s1_last_r && out_valid_r && out_stall);
  assign s1_done  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  // back-to-back access to one entry (single-column grid): take the
  // value being written instead of the stale RAM read
  assign prev_col = s1_first_row_r ? '0 : (s1_fwd_r ? fwd_data_r : rd_data_r);

  assign row_progress_nxt = ((row_progress_r << 1) | prog_t'(1)) & s1_mask_r;
  assign vv               = ((prev_col << 1) | prog_t'(1)) & s1_mask_r;
  assign hit_h            = |(row_progress_nxt & hit_m);
  assign hit_v            = |(vv & hit_m);

  assign total_sum = (TOTAL_W+1)'(running_total_r) + (TOTAL_W+1)'(hit_h)
                   + (TOTAL_W+1)'(hit_v);
  assign running_total_nxt = (total_sum > (TOTAL_W+1)'(TOTAL_MAX)) ? TOTAL_MAX
                                                                   : total_sum[TOTAL_W-1:0];

  // column store
  prog_t col_mem [MAX_COLUMNS];

  always_ff @(posedge clk) begin
    if (s1_done) begin
      col_mem[s1_col_r] <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= col_mem[column_position_r];
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mask_r      <= char_mask(pattern_bytes_r, len_c, in_cell_char);
      s1_col_r       <= column_position_r;
      s1_first_row_r <= (row_position_r == '0);
      s1_row_end_r   <= row_end;
      s1_last_r      <= frame_end;
      s1_fwd_r       <= s1_done && (s1_col_r == column_position_r);
      fwd_data_r     <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_progress_r  <= '0;
      running_total_r <= '0;
    end else if (s1_done) begin
      row_progress_r  <= s1_row_end_r ? '0 : row_progress_nxt;
      running_total_r <= s1_last_r ? '0 : running_total_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_done && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done && s1_last_r) begin
      out_total_r <= running_total_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_total = out_total_r;

endmodule

>>> rtl/gwm_checker.sv
// Port-level assertions for the grid word match counter, bound to the top level.
module gwm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [gwm_pkg::TOTAL_W-1:0] out_match_total
);
  import gwm_pkg::*;

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_total))
    else $error("result changed or dropped while stalled");

  // input backpressure only comes from a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // a new result must trace back to a cell taken earlier through stage 1
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a preceding cell");

  // reset empties the result register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind grid_word_match_counter_top gwm_checker u_gwm_checker (.*);
